[hw/rtl/bad_pkg.sv]
// bad_pkg: shared types and constants of the bounded array deque
`default_nettype none

package bad_pkg;

    // default sizes
    localparam int MAX_ELEMENTS_DEF = 256;
    localparam int ELEMENT_BITS_DEF = 32;

    // fixed port field widths
    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 8;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 9;
    localparam int STATUS_W  = 2;
    localparam int CAP_W     = 9;

    // capacity limit after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // command codes
    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD  = 3'd0,
        OP_INS_TAIL  = 3'd1,
        OP_REM_HEAD  = 3'd2,
        OP_REM_TAIL  = 3'd3,
        OP_READ_POS  = 3'd4,
        OP_READ_TAIL = 3'd5
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // per-command result info from the control unit
    typedef struct packed {
        logic    rd;
        status_t status;
    } res_t;

endpackage

`default_nettype wire

[hw/rtl/bounded_array_deque.sv]
// bounded_array_deque: top level of the bounded deque with indexed read
//
//  channel  | direction | tdata (low bit up)                 | tuser
//  s_       | in        | element_value[31:0], position[39:32] | op[2:0]
//  m_       | out       | read_data[31:0], element_count[40:32], zero pad | status[1:0]
//  cfg_     | in        | cfg_wr_data = capacity_limit, written when cfg_wr_en | -
//
// one command per cycle while s_tready is high; each command makes at most one access on the single memory port
// the result word passes through the pending stage into the output register
// a pending stage holds a result while the output register is stalled
// s_tready drops only when both the pending stage and the output register hold a word
// and m_tready is low
// reset clears head and count and sets the capacity limit to 256; memory is not cleared
`default_nettype none

module bounded_array_deque
    import bad_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // capacity limit register
    input  wire logic             cfg_wr_en,
    input  wire logic [CAP_W-1:0] cfg_wr_data,
    // command words
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [39:0]      s_tdata,   // element_value[31:0], position[39:32]
    input  wire logic [OP_W-1:0]  s_tuser,   // op[2:0]
    // result words
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [47:0]      m_tdata,   // read_data[31:0], element_count[40:32], pad
    output logic [STATUS_W-1:0]   m_tuser    // status[1:0]
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic                    accept;
    logic                    mem_en, mem_we;
    logic [AW-1:0]           mem_addr;
    logic [ELEMENT_BITS-1:0] mem_wdata, mem_rdata;
    res_t                    res;
    logic [CW-1:0]           count_next;

    logic           pend_valid_reg;
    res_t           pend_res_reg;
    logic [CW-1:0]  pend_count_reg;
    logic           pend_move;

    logic                   out_valid_reg;
    logic [DATA_W-1:0]      out_data_reg;
    logic [COUNT_W-1:0]     out_count_reg;
    logic [STATUS_W-1:0]    out_status_reg;

    logic [ELEMENT_BITS+DATA_W-1:0] rd_wide;
    logic [CW+COUNT_W-1:0]          cnt_wide;

    // handshake
    assign s_tready  = !pend_valid_reg || !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign pend_move = pend_valid_reg && (!out_valid_reg || m_tready);

    bad_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .accept        (accept),
        .op            (s_tuser),
        .element_value (s_tdata[31:0]),
        .position      (s_tdata[39:32]),
        .mem_en        (mem_en),
        .mem_we        (mem_we),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .res           (res),
        .count_next    (count_next)
    );

    bad_mem #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH (ELEMENT_BITS)
    ) u_mem (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // result fields sized to the port
    assign rd_wide  = (ELEMENT_BITS + DATA_W)'(mem_rdata);
    assign cnt_wide = (CW + COUNT_W)'(pend_count_reg);

    // pending stage: waits for memory read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (accept) begin
            pend_valid_reg <= 1'b1;
        end else if (pend_move) begin
            pend_valid_reg <= 1'b0;
        end
        if (accept) begin
            pend_res_reg   <= res;
            pend_count_reg <= count_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pend_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (pend_move) begin
            out_data_reg   <= pend_res_reg.rd ? rd_wide[DATA_W-1:0] : '0;
            out_count_reg  <= cnt_wide[COUNT_W-1:0];
            out_status_reg <= pend_res_reg.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_count_reg, out_data_reg};
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

[hw/rtl/bad_mem.sv]
// bad_mem: single-port element memory with registered read data
`default_nettype none

module bad_mem
    import bad_pkg::*;
#(
    parameter int DEPTH = MAX_ELEMENTS_DEF,
    parameter int WIDTH = ELEMENT_BITS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write or read one entry; read data holds until the next read
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/bad_ctrl.sv]
// bad_ctrl: head pointer, count and capacity limit; memory address generation
`default_nettype none

module bad_ctrl
    import bad_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF,
    localparam int AW = $clog2(MAX_ELEMENTS),
    localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CAP_W-1:0]        cfg_wr_data,
    input  wire logic                    accept,
    input  wire logic [OP_W-1:0]         op,
    input  wire logic [VALUE_W-1:0]      element_value,
    input  wire logic [POS_W-1:0]        position,
    output logic                         mem_en,
    output logic                         mem_we,
    output logic      [AW-1:0]           mem_addr,
    output logic      [ELEMENT_BITS-1:0] mem_wdata,
    output res_t                         res,
    output logic      [CW-1:0]           count_next
);

    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [AW:0] MAX_SUM = (AW + 1)'(MAX_ELEMENTS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_ELEMENTS - 1);

    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg;
    logic [CAP_W-1:0] cap_reg;

    logic [LW-1:0]           cap_w, lim_w;
    logic                    full, empty, pos_ok;
    logic [AW+POS_W-1:0]     pos_wide;
    logic [CW+AW-1:0]        cnt_wide, cntm1_wide;
    logic [ELEMENT_BITS+VALUE_W-1:0] val_wide;
    logic [AW-1:0]           pos_slot, tail_slot, last_slot, head_dec, head_inc;

    // ring slot of a logical position
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                              input logic [AW-1:0] p);
        logic [AW:0] s;
        s = {1'b0, h} + {1'b0, p};
        if (s >= MAX_SUM) begin
            s = s - MAX_SUM;
        end
        return s[AW-1:0];
    endfunction

    // limit in force and list conditions
    assign cap_w  = LW'(cap_reg);
    assign lim_w  = (cap_w > LW'(MAX_ELEMENTS)) ? LW'(MAX_ELEMENTS) : cap_w;
    assign full   = LW'(count_reg) >= lim_w;
    assign empty  = (count_reg == '0);
    assign pos_ok = PW'(position) < PW'(count_reg);

    // slot addresses
    assign pos_wide   = (AW + POS_W)'(position);
    assign cnt_wide   = (CW + AW)'(count_reg);
    assign cntm1_wide = (CW + AW)'(count_reg - CW'(1));
    assign pos_slot   = slot_of(head_reg, pos_wide[AW-1:0]);
    assign tail_slot  = slot_of(head_reg, cnt_wide[AW-1:0]);
    assign last_slot  = slot_of(head_reg, cntm1_wide[AW-1:0]);
    assign head_dec   = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);
    assign head_inc   = slot_of(head_reg, AW'(1));

    // element word kept to the element width
    assign val_wide  = (ELEMENT_BITS + VALUE_W)'(element_value);
    assign mem_wdata = val_wide[ELEMENT_BITS-1:0];

    // command decode
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = pos_slot;
        res.rd     = 1'b0;
        res.status = ST_OK;
        unique case (op)
            OP_INS_HEAD: begin
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                    mem_en     = 1'b1;
                    mem_we     = 1'b1;
                    mem_addr   = head_dec;
                end
            end
            OP_INS_TAIL: begin
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    count_next = count_reg + CW'(1);
                    mem_en     = 1'b1;
                    mem_we     = 1'b1;
                    mem_addr   = tail_slot;
                end
            end
            OP_REM_HEAD: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_REM_TAIL: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    count_next = count_reg - CW'(1);
                end
            end
            OP_READ_POS: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else if (!pos_ok) begin
                    res.status = ST_RANGE;
                end else begin
                    mem_en   = 1'b1;
                    mem_addr = pos_slot;
                    res.rd   = 1'b1;
                end
            end
            OP_READ_TAIL: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    mem_en   = 1'b1;
                    mem_addr = last_slot;
                    res.rd   = 1'b1;
                end
            end
            default: begin
                res.status = ST_OK;
            end
        endcase
        if (!accept) begin
            mem_en = 1'b0;
        end
    end

    // pointer, count and limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end else begin
            if (accept) begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire
